// ----- hdl/smu_pkg.sv -----
// ----------------------------------------------------------------------------
// smu_pkg
// Shared types and constants for the scoped map with undo log: default
// sizes, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package smu_pkg;

    // Default sizes
    localparam int KEY_BITS_DEF  = 10;
    localparam int NAME_BITS_DEF = 16;
    localparam int LOG_DEPTH_DEF = 256;

    // Operation codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_DEFINE = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_UNDO   = 2'd2
    } mode_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_UNDO,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/smu_req_if.sv -----
// ----------------------------------------------------------------------------
// smu_req_if
// Request channel: one beat carries one define, lookup or rollback.
// ----------------------------------------------------------------------------
interface smu_req_if #(
    parameter int KEY_BITS  = smu_pkg::KEY_BITS_DEF,
    parameter int NAME_BITS = smu_pkg::NAME_BITS_DEF,
    parameter int LVL_BITS  = $clog2(smu_pkg::LOG_DEPTH_DEF + 1)
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic [KEY_BITS-1:0]  key;
    logic [NAME_BITS-1:0] bind_name;
    logic [LVL_BITS-1:0]  return_level;

    modport source (
        output valid, mode, key, bind_name, return_level,
        input  ready
    );

    modport sink (
        input  valid, mode, key, bind_name, return_level,
        output ready
    );
endinterface

// ----- hdl/smu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// smu_rsp_if
// Response channel: one beat per request with lookup result and log level.
// ----------------------------------------------------------------------------
interface smu_rsp_if #(
    parameter int NAME_BITS = smu_pkg::NAME_BITS_DEF,
    parameter int LVL_BITS  = $clog2(smu_pkg::LOG_DEPTH_DEF + 1)
);
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [NAME_BITS-1:0] resolved_name;
    logic [LVL_BITS-1:0]  log_level;
    logic                 overflow;

    modport source (
        output valid, found, resolved_name, log_level, overflow,
        input  ready
    );

    modport sink (
        input  valid, found, resolved_name, log_level, overflow,
        output ready
    );
endinterface

// ----- hdl/smu_ram.sv -----
// ----------------------------------------------------------------------------
// smu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/scoped_map_with_undo_log_top.sv -----
// ----------------------------------------------------------------------------
// scoped_map_with_undo_log_top
// Key-to-name map with an undo log. Define logs the old mapping and sets a
// new one, lookup reports the mapping, rollback pops the log to a level.
//
//   Channel  Dir  Beat contents
//   req      in   mode, key, bind_name, return_level
//   rsp      out  found, resolved_name, log_level, overflow
//
// Define and lookup run map RAM read, map/log update and response load.
// Rollback pops one log entry per cycle, one log RAM read and one map RAM
// write each. A full-log define, a no-op rollback and other requests go
// straight to the response load. After reset a clearing pass writes every
// map entry with req.ready low. A response waiting on rsp does not block
// the next request; only the response load stalls until rsp is free.
// ----------------------------------------------------------------------------
module scoped_map_with_undo_log_top #(
    parameter int KEY_BITS  = smu_pkg::KEY_BITS_DEF,
    parameter int NAME_BITS = smu_pkg::NAME_BITS_DEF,
    parameter int LOG_DEPTH = smu_pkg::LOG_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    smu_req_if.sink   req,
    smu_rsp_if.source rsp
);
    import smu_pkg::*;

    localparam int LVL_BITS = $clog2(LOG_DEPTH + 1);
    localparam int LA_BITS  = $clog2(LOG_DEPTH);
    localparam int MAP_W    = NAME_BITS + 1;
    localparam int LOG_W    = KEY_BITS + 1 + NAME_BITS;
    localparam int MAP_SIZE = 2 ** KEY_BITS;

    // Control state
    state_t              state_reg, state_next;
    logic [KEY_BITS-1:0] clr_reg, clr_next;
    logic [LVL_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    // Latched request and pending result
    logic [1:0]           mode_reg, mode_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [NAME_BITS-1:0] name_reg, name_next;
    logic [LVL_BITS-1:0]  lvl_reg, lvl_next;
    logic                 found_res_reg, found_res_next;
    logic [NAME_BITS-1:0] rname_res_reg, rname_res_next;
    logic                 ovf_res_reg, ovf_res_next;

    // Output beat
    logic                 found_out_reg, found_out_next;
    logic [NAME_BITS-1:0] rname_out_reg, rname_out_next;
    logic [LVL_BITS-1:0]  lvl_out_reg, lvl_out_next;
    logic                 ovf_out_reg, ovf_out_next;

    // RAM ports
    logic                 map_we;
    logic [KEY_BITS-1:0]  map_waddr, map_raddr;
    logic [MAP_W-1:0]     map_wdata, map_rdata;
    logic                 log_we;
    logic [LA_BITS-1:0]   log_waddr, log_raddr;
    logic [LOG_W-1:0]     log_wdata, log_rdata;

    logic [LVL_BITS-1:0]  cnt_dec, cnt_dec2;
    logic                 map_hit;
    logic [NAME_BITS-1:0] map_name;
    logic [KEY_BITS-1:0]  ent_key;
    logic                 ent_had;
    logic [NAME_BITS-1:0] ent_old;
    logic                 out_free;

    assign cnt_dec  = cnt_reg - LVL_BITS'(1);
    assign cnt_dec2 = cnt_reg - LVL_BITS'(2);
    assign map_hit  = map_rdata[NAME_BITS];
    assign map_name = map_rdata[NAME_BITS-1:0];
    assign ent_key  = log_rdata[LOG_W-1 -: KEY_BITS];
    assign ent_had  = log_rdata[NAME_BITS];
    assign ent_old  = log_rdata[NAME_BITS-1:0];
    assign out_free = !out_valid_reg || rsp.ready;

    // Map store: valid bit over name
    smu_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAP_SIZE)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Undo log: key, had-mapping bit, old name
    smu_ram #(
        .WIDTH (LOG_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .we    (log_we),
        .waddr (log_waddr),
        .wdata (log_wdata),
        .raddr (log_raddr),
        .rdata (log_rdata)
    );

    // Sequencer: next state, RAM controls and result
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        name_next      = name_reg;
        lvl_next       = lvl_reg;
        found_res_next = found_res_reg;
        rname_res_next = rname_res_reg;
        ovf_res_next   = ovf_res_reg;
        found_out_next = found_out_reg;
        rname_out_next = rname_out_reg;
        lvl_out_next   = lvl_out_reg;
        ovf_out_next   = ovf_out_reg;

        map_we    = 1'b0;
        map_waddr = key_reg;
        map_wdata = {1'b1, name_reg};
        map_raddr = req.key;
        log_we    = 1'b0;
        log_waddr = cnt_reg[LA_BITS-1:0];
        log_wdata = {key_reg, map_hit, (map_hit ? map_name : {NAME_BITS{1'b0}})};
        log_raddr = cnt_dec[LA_BITS-1:0];

        // Drop the output beat once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the map, one entry per cycle
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
                clr_next  = clr_reg + KEY_BITS'(1);
                if (clr_reg == {KEY_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next      = req.mode;
                    key_next       = req.key;
                    name_next      = req.bind_name;
                    lvl_next       = req.return_level;
                    found_res_next = 1'b0;
                    rname_res_next = '0;
                    ovf_res_next   = 1'b0;
                    case (req.mode)
                        MODE_DEFINE:
                        begin
                            if (cnt_reg == LVL_BITS'(LOG_DEPTH))
                            begin
                                ovf_res_next = 1'b1;
                                state_next   = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_MAP;
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            state_next = ST_MAP;
                        end
                        MODE_UNDO:
                        begin
                            // Fetch the newest entry when there is one to pop
                            if (req.return_level < cnt_reg)
                            begin
                                state_next = ST_UNDO;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_MAP:
            begin
                if (mode_reg == MODE_DEFINE)
                begin
                    // Log the old mapping, then set the new one
                    log_we   = 1'b1;
                    map_we   = 1'b1;
                    cnt_next = cnt_reg + LVL_BITS'(1);
                end
                else
                begin
                    found_res_next = map_hit;
                    rname_res_next = map_hit ? map_name : {NAME_BITS{1'b0}};
                end
                state_next = ST_DONE;
            end

            ST_UNDO:
            begin
                // Restore or remove one mapping, prefetch the next entry
                map_we    = 1'b1;
                map_waddr = ent_key;
                map_wdata = {ent_had, (ent_had ? ent_old : {NAME_BITS{1'b0}})};
                cnt_next  = cnt_dec;
                log_raddr = cnt_dec2[LA_BITS-1:0];
                if (cnt_dec <= lvl_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Load the output beat once the output stage is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_out_next = found_res_reg;
                    rname_out_next = rname_res_reg;
                    lvl_out_next   = cnt_reg;
                    ovf_out_next   = ovf_res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        name_reg      <= name_next;
        lvl_reg       <= lvl_next;
        found_res_reg <= found_res_next;
        rname_res_reg <= rname_res_next;
        ovf_res_reg   <= ovf_res_next;
        found_out_reg <= found_out_next;
        rname_out_reg <= rname_out_next;
        lvl_out_reg   <= lvl_out_next;
        ovf_out_reg   <= ovf_out_next;
    end

    // Ports
    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = found_out_reg;
    assign rsp.resolved_name = rname_out_reg;
    assign rsp.log_level     = lvl_out_reg;
    assign rsp.overflow      = ovf_out_reg;

    // Log level never passes the log depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LVL_BITS'(LOG_DEPTH))
        else $error("log level above depth");

    // A rollback below the level walks the log
    a_undo_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.mode == MODE_UNDO && req.return_level < cnt_reg)
        |=> state_reg == ST_UNDO)
        else $error("rollback did not start");

    // Each rollback cycle pops exactly one entry
    a_undo_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UNDO |=> cnt_reg == $past(cnt_reg) - LVL_BITS'(1))
        else $error("rollback pop count wrong");

    // Overflow is only reported with a full log
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.overflow) |-> rsp.log_level == LVL_BITS'(LOG_DEPTH))
        else $error("overflow with log not full");

    // No request is taken during the clearing pass
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !req.ready)
        else $error("request taken while clearing");
endmodule
